// ===== src/mcsa_pkg.sv =====
// mcsa_pkg: types and constants shared by the motion command source arbiter
// holds tick and write payload structs, state and mode codes, and the run descriptor
// no dependencies
package mcsa_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int RUN_SLOTS       = 6;
    localparam int SLOT_W          = $clog2(RUN_SLOTS);

    typedef enum logic [1:0] {
        ST_START     = 2'd0,
        ST_FOLLOWING = 2'd1,
        ST_JOYSTICK  = 2'd2,
        ST_EMERGENCY = 2'd3
    } arb_state_t;

    typedef enum logic [1:0] {
        MODE_DRIVING       = 2'd0,
        MODE_WHEEL_WALKING = 2'd1,
        MODE_DONT_CARE     = 2'd2
    } loco_mode_t;

    typedef enum logic {
        KIND_MOTION = 1'b0,
        KIND_MODE   = 1'b1
    } write_kind_t;

    // slot positions of a run, in emission order
    localparam logic [SLOT_W-1:0] SLOT_FAULT_STOP  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_FAULT_MODE  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_BUTTON_MODE = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_COMMAND     = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_SWITCH_MOVE = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_SWITCH_MODE = SLOT_W'(5);

    typedef struct packed {
        logic               fault_valid;
        logic               fault_flag;
        logic               buttons_valid;
        logic               source_button;
        logic               mode_button;
        logic               joy_valid;
        logic signed [15:0] joy_translation;
        logic signed [15:0] joy_rotation;
        logic               follow_valid;
        logic signed [15:0] follow_translation;
        logic signed [15:0] follow_rotation;
    } tick_t;

    typedef struct packed {
        logic               write_kind;
        logic signed [15:0] out_translation;
        logic signed [15:0] out_rotation;
        logic [1:0]         out_mode;
        logic [1:0]         arbiter_status;
        logic               last_of_run;
    } write_t;

    // one tick worth of writes, expanded by the back end
    typedef struct packed {
        logic [RUN_SLOTS-1:0] mask;
        arb_state_t           status_entry;
        arb_state_t           status_mid;
        arb_state_t           status_final;
        loco_mode_t           button_mode;
        logic signed [15:0]   cmd_translation;
        logic signed [15:0]   cmd_rotation;
        logic signed [15:0]   switch_translation;
        logic signed [15:0]   switch_rotation;
        loco_mode_t           switch_mode;
    } run_desc_t;

endpackage

// ===== src/motion_command_source_arbiter.sv =====
// motion_command_source_arbiter: top level, front classifier, descriptor queue, write sequencer
// depends on mcsa_pkg, mcsa_front, mcsa_queue, mcsa_back
//
//  channel   direction  handshake              payload
//  tick      in         push / full            tick_t  (one update tick)
//  result    out        pop / empty            write_t (one motion or mode write)
//
// a tick is classified in the cycle it is accepted; a tick that makes no write queues no descriptor
// a tick making 0 to 6 writes holds the sequencer, one write per cycle while output is free
// a write passes from acceptance through the queue, the run register, then the output register
// full rises only when the descriptor queue is full; the arbiter state needs no clearing pass
// reset is asynchronous and restores start state, following source, driving mode
module motion_command_source_arbiter
    import mcsa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  tick_t  tick,
    output logic   empty,
    input  logic   pop,
    output write_t result
);

    logic      accept;
    logic      desc_valid;
    run_desc_t desc;
    logic      q_empty, q_rd;
    run_desc_t q_data;

    assign accept = push && !full;

    mcsa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .tick       (tick),
        .desc_valid (desc_valid),
        .desc       (desc)
    );

    mcsa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (desc_valid),
        .wr_data (desc),
        .full    (full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    mcsa_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== src/mcsa_front.sv =====
// mcsa_front: arbiter state and classification of each tick into a run descriptor
// depends on mcsa_pkg
module mcsa_front
    import mcsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  tick_t     tick,
    output logic      desc_valid,
    output run_desc_t desc
);

    arb_state_t         state_reg, state_next;
    arb_state_t         saved_reg, saved_next;
    logic               src_joy_reg, src_joy_next;
    logic               wheel_reg, wheel_next;
    logic               prev_src_reg, prev_mode_reg;
    logic signed [15:0] held_tr_reg, held_tr_next;
    logic signed [15:0] held_rot_reg, held_rot_next;

    logic       fault_set, fault_clr, src_rise, mode_rise, blocked;
    logic       wheel_a, joy_w, fol_w, to_joy, to_fol;
    arb_state_t state_mid;

    always_comb
    begin
        fault_set = tick.fault_valid && tick.fault_flag &&
                    state_reg != ST_EMERGENCY && state_reg != ST_JOYSTICK;
        fault_clr = tick.fault_valid && !tick.fault_flag && state_reg == ST_EMERGENCY;
        saved_next = fault_set ? state_reg : saved_reg;
        if (fault_set)
            state_mid = ST_EMERGENCY;
        else if (fault_clr)
            state_mid = saved_reg;
        else
            state_mid = state_reg;
        wheel_a = fault_set ? 1'b0 : wheel_reg;

        src_rise     = tick.buttons_valid && tick.source_button && !prev_src_reg;
        mode_rise    = tick.buttons_valid && tick.mode_button && !prev_mode_reg;
        src_joy_next = src_joy_reg ^ src_rise;

        // emergency with following source ends the tick before any motion news
        blocked = state_mid == ST_EMERGENCY && !src_joy_next;
        joy_w   = !blocked && tick.joy_valid && src_joy_next;
        fol_w   = !blocked && tick.follow_valid && !src_joy_next;
        to_joy  = !blocked && src_joy_next && state_mid != ST_JOYSTICK;
        to_fol  = !blocked && !src_joy_next && state_mid != ST_FOLLOWING;

        if (!blocked && tick.follow_valid)
        begin
            held_tr_next  = tick.follow_translation;
            held_rot_next = tick.follow_rotation;
        end
        else
        begin
            held_tr_next  = held_tr_reg;
            held_rot_next = held_rot_reg;
        end

        if (to_joy)
            state_next = ST_JOYSTICK;
        else if (to_fol)
            state_next = ST_FOLLOWING;
        else
            state_next = state_mid;

        wheel_next = to_joy ? 1'b0 : (wheel_a ^ mode_rise);

        desc.mask         = {to_joy || to_fol, to_joy || to_fol, joy_w || fol_w,
                             mode_rise, fault_set, fault_set};
        desc.status_entry = state_reg;
        desc.status_mid   = state_mid;
        desc.status_final = state_next;
        desc.button_mode  = (wheel_a ^ mode_rise) ? MODE_WHEEL_WALKING : MODE_DRIVING;
        desc.cmd_translation = joy_w ? tick.joy_translation : tick.follow_translation;
        desc.cmd_rotation    = joy_w ? tick.joy_rotation : tick.follow_rotation;
        desc.switch_translation = to_joy ? 16'sd0 : held_tr_next;
        desc.switch_rotation    = to_joy ? 16'sd0 : held_rot_next;
        desc.switch_mode        = to_joy ? MODE_DRIVING : MODE_DONT_CARE;

        desc_valid = accept && (desc.mask != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            saved_reg     <= ST_FOLLOWING;
            src_joy_reg   <= 1'b0;
            wheel_reg     <= 1'b0;
            prev_src_reg  <= 1'b0;
            prev_mode_reg <= 1'b0;
            held_tr_reg   <= '0;
            held_rot_reg  <= '0;
        end
        else if (accept)
        begin
            state_reg    <= state_next;
            saved_reg    <= saved_next;
            src_joy_reg  <= src_joy_next;
            wheel_reg    <= wheel_next;
            held_tr_reg  <= held_tr_next;
            held_rot_reg <= held_rot_next;
            if (tick.buttons_valid)
            begin
                prev_src_reg  <= tick.source_button;
                prev_mode_reg <= tick.mode_button;
            end
        end
    end

endmodule

// ===== src/mcsa_queue.sv =====
// mcsa_queue: short descriptor queue between front and back end
// depends on mcsa_pkg
module mcsa_queue
    import mcsa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  run_desc_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output run_desc_t rd_data,
    output logic      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    run_desc_t          mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr, do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== src/mcsa_back.sv =====
// mcsa_back: expands run descriptors into writes, one per cycle while the output register is free, into that register
// depends on mcsa_pkg
module mcsa_back
    import mcsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  run_desc_t q_data,
    output logic      q_rd,
    output logic      empty,
    input  logic      pop,
    output write_t    result
);

    run_desc_t            cur_reg;
    logic                 cur_valid_reg;
    logic [RUN_SLOTS-1:0] rem_reg;
    logic                 out_valid_reg;
    write_t               out_reg;

    logic [RUN_SLOTS-1:0] low;
    logic [SLOT_W-1:0]    slot;
    logic                 last, out_free, emit_go, load;
    write_t               wr;

    always_comb
    begin
        low  = rem_reg & (~rem_reg + 1'b1);
        last = (rem_reg & ~low) == '0;
        slot = '0;
        for (int i = 0; i < RUN_SLOTS; i++)
        begin
            if (low[i])
                slot = SLOT_W'(i);
        end

        out_free = !out_valid_reg || pop;
        emit_go  = cur_valid_reg && out_free;
        load     = !q_empty && (!cur_valid_reg || (emit_go && last));
        q_rd     = load;

        wr.write_kind      = KIND_MOTION;
        wr.out_translation = '0;
        wr.out_rotation    = '0;
        wr.out_mode        = MODE_DRIVING;
        wr.arbiter_status  = cur_reg.status_entry;
        wr.last_of_run     = last;
        case (slot)
            SLOT_FAULT_STOP:
            begin
                wr.arbiter_status = cur_reg.status_entry;
            end
            SLOT_FAULT_MODE:
            begin
                wr.write_kind     = KIND_MODE;
                wr.arbiter_status = cur_reg.status_entry;
            end
            SLOT_BUTTON_MODE:
            begin
                wr.write_kind     = KIND_MODE;
                wr.out_mode       = cur_reg.button_mode;
                wr.arbiter_status = cur_reg.status_mid;
            end
            SLOT_COMMAND:
            begin
                wr.out_translation = cur_reg.cmd_translation;
                wr.out_rotation    = cur_reg.cmd_rotation;
                wr.arbiter_status  = cur_reg.status_mid;
            end
            SLOT_SWITCH_MOVE:
            begin
                wr.out_translation = cur_reg.switch_translation;
                wr.out_rotation    = cur_reg.switch_rotation;
                wr.arbiter_status  = cur_reg.status_final;
            end
            SLOT_SWITCH_MODE:
            begin
                wr.write_kind     = KIND_MODE;
                wr.out_mode       = cur_reg.switch_mode;
                wr.arbiter_status = cur_reg.status_final;
            end
            default:
            begin
                wr.arbiter_status = cur_reg.status_final;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_data;
        if (emit_go)
            out_reg <= wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                rem_reg       <= q_data.mask;
            end
            else if (emit_go)
            begin
                rem_reg <= rem_reg & ~low;
                if (last)
                    cur_valid_reg <= 1'b0;
            end
            if (emit_go)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

`ifndef ASSERT_OFF
    a_cur_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> rem_reg != '0)
        else $error("active run with no writes left");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && last) |=> (out_valid_reg && out_reg.last_of_run))
        else $error("final write of a run not marked");

    a_mid_unmarked: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && !last) |=> (out_valid_reg && !out_reg.last_of_run))
        else $error("inner write of a run marked as last");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> cur_valid_reg)
        else $error("descriptor load did not start a run");
`endif

endmodule
